// File: rtl/core/mpbd_pkg.sv
// Shared types, mode tables and color helpers of the multi-palette bitplane decoder.
package mpbd_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_STE   = 2'd1;
    localparam logic [1:0] CFG_EXTRA = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXT,
        S_COL,
        S_WR,
        S_CNT,
        S_PX_BEGIN,
        S_LD_RD,
        S_LD_CAP,
        S_CHG_CHK,
        S_CHG_CAP,
        S_EMIT
    } t_state;

    // Control group toward the active palette / pixel shifter
    typedef struct packed {
        logic        clear;
        logic        wr_en;
        logic [3:0]  wr_idx;
        logic [23:0] wr_data;
        logic        load_sh;
        logic        shift_sh;
    } t_act_ctl;

    function automatic logic [5:0] f_ncolors(input logic [1:0] m);
        case (m)
            2'd0:    return 6'd54;
            2'd1:    return 6'd48;
            2'd2:    return 6'd56;
            default: return 6'd54;
        endcase
    endfunction

    function automatic logic [3:0] f_nfixed(input logic [1:0] m);
        case (m)
            2'd3:    return 4'd6;
            default: return 4'd0;
        endcase
    endfunction

    function automatic logic f_border(input logic [1:0] m);
        case (m)
            2'd3:    return 1'b0;
            default: return 1'b1;
        endcase
    endfunction

    // Second border slot of a line: (ncolors - 1) rounded down to 16
    function automatic logic [5:0] f_border_col(input logic [1:0] m);
        case (m)
            2'd0:    return 6'd48;
            2'd1:    return 6'd32;
            2'd2:    return 6'd48;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic [8:0] f_x0(input logic [1:0] m);
        case (m)
            2'd0:    return 9'd33;
            2'd1:    return 9'd9;
            2'd2:    return 9'd4;
            default: return 9'd69;
        endcase
    endfunction

    function automatic logic [8:0] f_width(input logic [1:0] m);
        case (m)
            2'd3:    return 9'd416;
            default: return 9'd320;
        endcase
    endfunction

    function automatic logic [8:0] f_height(input logic [1:0] m);
        case (m)
            2'd3:    return 9'd273;
            default: return 9'd199;
        endcase
    endfunction

    // Palette entries stored per line
    function automatic logic [5:0] f_stride(input logic [1:0] m);
        case (m)
            2'd0:    return 6'd54;
            2'd1:    return 6'd48;
            2'd2:    return 6'd56;
            default: return 6'd48;
        endcase
    endfunction

    function automatic logic [13:0] f_pal_size(input logic [1:0] m);
        case (m)
            2'd0:    return 14'd10746;
            2'd1:    return 14'd9552;
            2'd2:    return 14'd11144;
            default: return 14'd13104;
        endcase
    endfunction

    // Packed palette length in bytes, per mode and color size
    function automatic logic [16:0] f_packed(input logic [1:0] m, input logic [1:0] csel);
        logic [3:0] k;
        k = {m, csel};
        case (k)
            4'h0:    return 17'd11642;
            4'h1:    return 17'd15522;
            4'h2:    return 17'd19404;
            4'h4:    return 17'd10300;
            4'h5:    return 17'd13732;
            4'h6:    return 17'd17164;
            4'h8:    return 17'd12090;
            4'h9:    return 17'd16120;
            4'hA:    return 17'd20150;
            4'hC:    return 17'd14742;
            4'hD:    return 17'd19656;
            4'hE:    return 17'd24570;
            default: return 17'd11642;
        endcase
    endfunction

    function automatic logic [3:0] f_bits(input logic [1:0] csel);
        case (csel)
            2'd1:    return 4'd12;
            2'd2:    return 4'd15;
            default: return 4'd9;
        endcase
    endfunction

    function automatic logic [8:0] f_col_step(input logic [1:0] m, input logic [5:0] cc);
        case (m)
            2'd0: begin
                if (cc == 6'd15)      return 9'd88;
                else if (cc == 6'd31) return 9'd12;
                else if (cc == 6'd37) return 9'd100;
                else                  return 9'd4;
            end
            2'd1:    return cc[0] ? 9'd16 : 9'd4;
            2'd2:    return 9'd8;
            default: begin
                if (cc == 6'd15)      return 9'd112;
                else if (cc == 6'd31) return 9'd12;
                else if (cc == 6'd37) return 9'd100;
                else                  return 9'd4;
            end
        endcase
    endfunction

    // Spread a packed color into 8-bit components
    function automatic logic [23:0] f_unpack(input logic [14:0] c, input logic [1:0] csel);
        case (csel)
            2'd0:    return {c[8:6], 5'd0, c[5:3], 5'd0, c[2:0], 5'd0};
            2'd1:    return {c[10:8], c[11], 4'd0, c[6:4], c[7], 4'd0,
                             c[2:0], c[3], 4'd0};
            2'd2:    return {c[10:8], c[11], c[14], 3'd0, c[6:4], c[7], c[13], 3'd0,
                             c[2:0], c[3], c[12], 3'd0};
            default: return 24'd0;
        endcase
    endfunction

endpackage

// File: rtl/core/mpbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mpbd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/mpbd_act_pal.sv
// Active 16-entry palette and the bitplane shifter that picks one entry per pixel.
module mpbd_act_pal
    import mpbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_act_ctl    i_ctl,
    input  logic [63:0] i_planes,
    output logic [23:0] o_rgb
);

    logic [23:0] r_pal [16];
    logic [63:0] r_sh;
    logic [3:0]  w_idx;

    // Clear all palette entries or update one entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int i = 0; i < 16; i++) begin
                r_pal[i] <= 24'd0;
            end
        end else if (i_ctl.wr_en) begin
            r_pal[i_ctl.wr_idx] <= i_ctl.wr_data;
        end
    end

    // Load a group of plane words, then advance one pixel per shift
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_sh) begin
            r_sh <= i_planes;
        end else if (i_ctl.shift_sh) begin
            r_sh <= {r_sh[62:0], 1'b0};
        end
    end

    // One bit from each of the four planes forms the color index
    assign w_idx = {r_sh[15], r_sh[31], r_sh[47], r_sh[63]};
    assign o_rgb = r_pal[w_idx];

endmodule

// File: rtl/core/multi_palette_bitplane_decoder_core.sv
// Top level of the multi-palette bitplane picture decoder.
// Usage:
//   The input channel (i_in_valid / o_in_stall) carries one picture body byte per
//   transfer; i_frame_start marks the first byte of a picture. The first bytes are
//   the packed palette, the rest are interleaved 4-plane image words.
//   The output channel (o_out_valid / i_out_stall) carries one RGB pixel per
//   transfer, with last-of-group and end-of-image flags.
//   Configuration (mode, STE bits, extra bit) is written over i_cfg_valid /
//   o_cfg_ready with a register index; write it between pictures.
// Timing:
//   A palette byte is loaded into the bit buffer; each color it completes is then
//   read out bit by bit (9, 12 or 15 bits) and written, and each border slot is written as zero.
//   Image bytes are shifted into the plane words; every eighth byte starts a group of 16
//   pixels, each with an extra store read when an entry changes, as the single store port
//   reads entries one at a time; the first pixel of a line first loads its entries.
//   Results appear through one output register, so the pixel loop only waits
//   while that register is full and stalled.
// Reset:
//   Synchronous active-low reset clears the decode FSM, counters, pointers and configuration.
//   The palette store is not cleared; every entry is written before it is read.
module multi_palette_bitplane_decoder_core
    import mpbd_pkg::*;
#(
    parameter int PALETTE_DEPTH = 16384
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_start,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic       o_last_of_group,
    output logic       o_end_of_image,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [1:0] i_cfg_data
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    t_state r_state, n_state;

    logic [1:0]  r_mode;
    logic        r_ste, r_extra;
    logic [23:0] r_bitbuf;
    logic [4:0]  r_bitcnt;
    logic [16:0] r_bytecnt;
    logic [13:0] r_pwi, r_rp;
    logic [63:0] r_planes;
    logic [8:0]  r_line, r_col, r_nchg;
    logic [5:0]  r_cc;
    logic        r_img;
    logic [5:0]  r_xm [4];
    logic [7:0]  r_byte;
    logic        r_phase_b;
    logic [14:0] r_colw;
    logic [3:0]  r_kbit, r_ldi, r_pix;
    logic        r_rd_ok;
    logic        r_out_valid;
    logic [7:0]  r_red, r_green, r_blue;
    logic        r_last, r_eoi;

    logic [1:0]  w_csel;
    logic [3:0]  w_bits;
    logic        w_lt_n, w_fill, w_can_col, w_can_load;
    logic        w_in_acc, w_out_free, w_grp_byte, w_line_ok;
    logic [16:0] w_bytecnt_inc;
    logic [4:0]  w_bitsel;
    logic [9:0]  w_col_inc;
    logic        w_line_wrap;
    logic [8:0]  w_line_next;
    logic [14:0] w_line_base;
    logic [23:0] w_rdata, w_rd_val, w_rgb;
    logic        w_ram_we;
    logic [23:0] w_ram_wdata;
    logic [AW-1:0] w_ram_waddr, w_ram_raddr;
    t_act_ctl    w_act;

    // Derived decode conditions
    assign w_csel        = {1'b0, r_ste} + {1'b0, r_extra};
    assign w_bits        = f_bits(w_csel);
    assign w_lt_n        = r_pwi < f_pal_size(r_mode);
    assign w_fill        = f_border(r_mode) && w_lt_n &&
                           (r_xm[r_mode] == 6'd0 || r_xm[r_mode] == f_border_col(r_mode));
    assign w_can_col     = (r_bitcnt >= {1'b0, w_bits}) && w_lt_n;
    assign w_can_load    = !r_phase_b && w_lt_n && (r_bitcnt <= 5'd16);
    assign w_in_acc      = i_in_valid && !o_in_stall;
    assign w_out_free    = !r_out_valid || !i_out_stall;
    assign w_bytecnt_inc = r_bytecnt + 17'd1;
    assign w_line_ok     = r_line < f_height(r_mode);
    assign w_grp_byte    = w_line_ok && (w_bytecnt_inc[2:0] == 3'd0);
    assign w_bitsel      = r_bitcnt - 5'd1;
    assign w_col_inc     = {1'b0, r_col} + 10'd1;
    assign w_line_wrap   = w_col_inc >= {1'b0, f_width(r_mode)};
    assign w_line_next   = w_line_wrap ? r_line + 9'd1 : r_line;
    assign w_line_base   = r_line * f_stride(r_mode);
    assign w_rd_val      = r_rd_ok ? w_rdata : 24'd0;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_frame_start || !r_img) begin
                        n_state = S_EXT;
                    end else if (w_grp_byte) begin
                        n_state = S_PX_BEGIN;
                    end
                end
            end
            S_EXT: begin
                if (w_fill) begin
                    n_state = S_EXT;
                end else if (w_can_col) begin
                    n_state = S_COL;
                end else if (!w_can_load) begin
                    n_state = S_CNT;
                end
            end
            S_COL:      n_state = (r_kbit == w_bits - 4'd1) ? S_WR : S_COL;
            S_WR:       n_state = S_EXT;
            S_CNT:      n_state = S_IDLE;
            S_PX_BEGIN: n_state = (r_col == 9'd0) ? S_LD_RD : S_CHG_CHK;
            S_LD_RD:    n_state = S_LD_CAP;
            S_LD_CAP:   n_state = (r_ldi == 4'd15) ? S_CHG_CHK : S_LD_RD;
            S_CHG_CHK:  n_state = (r_col == r_nchg) ? S_CHG_CAP : S_EMIT;
            S_CHG_CAP:  n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_free) begin
                    if (r_pix == 4'd15 || w_line_next >= f_height(r_mode)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_PX_BEGIN;
                    end
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Store and palette controls
    always_comb begin
        w_ram_we         = 1'b0;
        w_ram_wdata      = 24'd0;
        w_act            = '0;
        w_act.wr_data    = w_rd_val;
        case (r_state)
            S_IDLE: begin
                w_act.clear   = w_in_acc && i_frame_start;
                w_act.load_sh = w_in_acc && !i_frame_start && r_img && w_grp_byte;
            end
            S_EXT: begin
                w_ram_we = w_fill;
            end
            S_WR: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = f_unpack(r_colw, w_csel);
            end
            S_LD_CAP: begin
                w_act.wr_en  = 1'b1;
                w_act.wr_idx = r_ldi;
            end
            S_CHG_CAP: begin
                w_act.wr_en  = 1'b1;
                w_act.wr_idx = r_cc[3:0];
            end
            S_EMIT: begin
                w_act.shift_sh = w_out_free;
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
        // drop writes beyond the store
        w_ram_we = w_ram_we && ({18'd0, r_pwi} < PALETTE_DEPTH);
    end

    assign w_ram_waddr = AW'(r_pwi);
    assign w_ram_raddr = AW'(r_rp);

    mpbd_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rdata)
    );

    mpbd_act_pal u_act (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_act),
        .i_planes ({r_planes[55:0], i_data_byte}),
        .o_rgb    (w_rgb)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 2'd0;
            r_ste   <= 1'b0;
            r_extra <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE:  r_mode  <= i_cfg_data;
                CFG_STE:   r_ste   <= i_cfg_data[0];
                CFG_EXTRA: r_extra <= i_cfg_data[0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    // Flag a store read that falls inside the store
    always_ff @(posedge i_clk) begin
        r_rd_ok <= {18'd0, r_rp} < PALETTE_DEPTH;
    end

    // Decode datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitbuf  <= 24'd0;
            r_bitcnt  <= 5'd0;
            r_bytecnt <= 17'd0;
            r_pwi     <= 14'd0;
            r_rp      <= 14'd0;
            r_planes  <= 64'd0;
            r_line    <= 9'd0;
            r_col     <= 9'd0;
            r_nchg    <= f_x0(2'd0);
            r_cc      <= 6'd0;
            r_img     <= 1'b0;
            for (int m = 0; m < 4; m++) begin
                r_xm[m] <= 6'd0;
            end
            r_phase_b <= 1'b0;
            r_kbit    <= 4'd0;
            r_ldi     <= 4'd0;
            r_pix     <= 4'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_byte    <= i_data_byte;
                        r_phase_b <= 1'b0;
                        if (i_frame_start) begin
                            // restart the picture
                            r_bitbuf  <= 24'd0;
                            r_bitcnt  <= 5'd0;
                            r_bytecnt <= 17'd0;
                            r_pwi     <= 14'd0;
                            r_rp      <= 14'd0;
                            r_planes  <= 64'd0;
                            r_line    <= 9'd0;
                            r_col     <= 9'd0;
                            r_nchg    <= f_x0(r_mode);
                            r_cc      <= 6'd0;
                            r_img     <= 1'b0;
                            for (int m = 0; m < 4; m++) begin
                                r_xm[m] <= 6'd0;
                            end
                        end else if (r_img && w_line_ok) begin
                            // shift in an image byte
                            r_planes  <= {r_planes[55:0], i_data_byte};
                            r_bytecnt <= w_bytecnt_inc;
                            r_pix     <= 4'd0;
                        end
                    end
                end
                S_EXT: begin
                    if (w_fill) begin
                        r_pwi <= r_pwi + 14'd1;
                        for (int m = 0; m < 4; m++) begin
                            r_xm[m] <= (r_xm[m] == f_ncolors(2'(m)) - 6'd1) ?
                                       6'd0 : r_xm[m] + 6'd1;
                        end
                    end else if (w_can_col) begin
                        r_colw <= 15'd0;
                        r_kbit <= 4'd0;
                    end else if (w_can_load) begin
                        r_bitbuf  <= {r_bitbuf[15:0], r_byte};
                        r_bitcnt  <= r_bitcnt + 5'd8;
                        r_phase_b <= 1'b1;
                    end
                end
                S_COL: begin
                    // take one color bit per cycle, MSB first
                    r_colw   <= {r_colw[13:0], r_bitbuf[w_bitsel]};
                    r_bitcnt <= w_bitsel;
                    r_kbit   <= r_kbit + 4'd1;
                end
                S_WR: begin
                    r_pwi <= r_pwi + 14'd1;
                    for (int m = 0; m < 4; m++) begin
                        r_xm[m] <= (r_xm[m] == f_ncolors(2'(m)) - 6'd1) ?
                                   6'd0 : r_xm[m] + 6'd1;
                    end
                end
                S_CNT: begin
                    if (w_bytecnt_inc >= f_packed(r_mode, w_csel)) begin
                        r_img     <= 1'b1;
                        r_bytecnt <= 17'd0;
                    end else begin
                        r_bytecnt <= w_bytecnt_inc;
                    end
                end
                S_PX_BEGIN: begin
                    if (r_col == 9'd0) begin
                        r_rp   <= w_line_base[13:0];
                        r_ldi  <= f_nfixed(r_mode);
                        r_nchg <= f_x0(r_mode);
                        r_cc   <= 6'd0;
                    end
                end
                S_LD_RD: begin
                    r_rp <= r_rp + 14'd1;
                end
                S_LD_CAP: begin
                    r_ldi <= r_ldi + 4'd1;
                end
                S_CHG_CHK: begin
                    if (r_col == r_nchg) begin
                        r_rp <= r_rp + 14'd1;
                    end
                end
                S_CHG_CAP: begin
                    r_nchg <= r_nchg + f_col_step(r_mode, r_cc);
                    r_cc   <= r_cc + 6'd1;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_pix  <= r_pix + 4'd1;
                        r_col  <= w_line_wrap ? 9'd0 : w_col_inc[8:0];
                        r_line <= w_line_next;
                    end
                end
                default: begin
                    r_pix <= r_pix;
                end
            endcase
        end
    end

    // Output register: hold while stalled, load a new pixel when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_out_free) begin
            r_red   <= w_rgb[23:16];
            r_green <= w_rgb[15:8];
            r_blue  <= w_rgb[7:0];
            r_last  <= r_pix == 4'd15;
            r_eoi   <= (r_line == f_height(r_mode) - 9'd1) &&
                       (r_col == f_width(r_mode) - 9'd1);
        end
    end

    assign o_in_stall      = r_state != S_IDLE;
    assign o_out_valid     = r_out_valid;
    assign o_red           = r_red;
    assign o_green         = r_green;
    assign o_blue          = r_blue;
    assign o_last_of_group = r_last;
    assign o_end_of_image  = r_eoi;
    assign o_cfg_ready     = 1'b1;

endmodule

// File: rtl/core/mpbd_checker.sv
// Port-level checks of the decoder, bound to the top level.
module mpbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_frame_start,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue,
    input logic       o_last_of_group,
    input logic       o_end_of_image
);

    // A stalled pixel stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled pixel keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_red) && $stable(o_green) &&
        $stable(o_blue) && $stable(o_last_of_group) && $stable(o_end_of_image)))
        else $error("output payload changed while stalled");

    // No pixel right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A frame start byte always goes through palette unpacking first
    a_frame_unpack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_frame_start) |=> o_in_stall)
        else $error("frame start byte not unpacked");

endmodule

bind multi_palette_bitplane_decoder_core mpbd_checker u_mpbd_checker (.*);

// File: sim/multi_palette_bitplane_decoder_core_tb.sv
// Testbench of the multi-palette bitplane decoder core: random pictures checked against a built-in predictor.
`timescale 1ns / 1ps

module multi_palette_bitplane_decoder_core_tb;
    import mpbd_pkg::*;

    localparam int STORE_DEPTH = 16384;

    typedef struct {
        logic [7:0] data;
        logic       first;
    } body_byte_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_of_group;
        logic       end_of_image;
    } pixel_t;

    typedef struct {
        int unsigned ncolors, nfixed, border, x0, width, height;
    } mode_info_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_data_byte;
    logic       i_frame_start;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;
    logic       o_last_of_group;
    logic       o_end_of_image;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [1:0] i_cfg_data;

    multi_palette_bitplane_decoder_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_frame_start  (i_frame_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_last_of_group(o_last_of_group),
        .o_end_of_image (o_end_of_image),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Stimulus and expectation stores
    body_byte_t  body_q[$];
    pixel_t      pixel_q[$];
    bit          holding;
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned mismatches;

    // Predictor state
    logic [1:0]  cur_mode;
    logic        cur_ste;
    logic        cur_extra;
    logic [23:0] pal_mem [STORE_DEPTH];
    logic [23:0] act_pal [16];
    logic [23:0] bit_buf;
    logic [4:0]  bit_cnt;
    logic [16:0] byte_cnt;
    logic [13:0] wr_ptr;
    logic [13:0] rd_ptr;
    logic [63:0] planes;
    logic [8:0]  line_no;
    logic [8:0]  col_no;
    logic [8:0]  next_chg;
    logic [5:0]  chg_cnt;
    logic        image_phase;

    function automatic mode_info_t mode_info(input logic [1:0] m);
        mode_info_t mi;
        case (m)
            2'd0:    mi = '{54, 0, 1, 33, 320, 199};
            2'd1:    mi = '{48, 0, 1, 9, 320, 199};
            2'd2:    mi = '{56, 0, 1, 4, 320, 199};
            default: mi = '{54, 6, 0, 69, 416, 273};
        endcase
        return mi;
    endfunction

    function automatic int unsigned change_step(input logic [1:0] m, input logic [5:0] c);
        case (m)
            2'd0:    return c == 15 ? 88 : c == 31 ? 12 : c == 37 ? 100 : 4;
            2'd1:    return c[0] ? 16 : 4;
            2'd2:    return 8;
            default: return c == 15 ? 112 : c == 31 ? 12 : c == 37 ? 100 : 4;
        endcase
    endfunction

    function automatic int unsigned color_width(input logic ste, input logic extra);
        return 3 * (3 + ste + extra);
    endfunction

    function automatic int unsigned packed_len(input logic [1:0] m, input logic ste,
                                               input logic extra);
        mode_info_t mi;
        mi = mode_info(m);
        return ((color_width(ste, extra) * (mi.ncolors - mi.nfixed - mi.border * 2)
                 * mi.height + 15) / 8) & ~32'd1;
    endfunction

    function automatic logic [23:0] store_rd(input int unsigned a);
        return a < STORE_DEPTH ? pal_mem[a] : 24'd0;
    endfunction

    function automatic void store_wr(input int unsigned a, input logic [23:0] v);
        if (a < STORE_DEPTH)
            pal_mem[a] = v;
    endfunction

    // Spread one packed color into 8-bit components
    function automatic logic [23:0] expand_color(input logic [14:0] c, input int unsigned bits);
        logic [7:0] r, g, b;
        if (bits == 9) begin
            r = c[8:6]; g = c[5:3]; b = c[2:0];
        end else begin
            r = {4'd0, c[10:8], c[11]};
            g = {4'd0, c[6:4], c[7]};
            b = {4'd0, c[2:0], c[3]};
            if (bits == 15) begin
                r = {r[6:0], c[14]};
                g = {g[6:0], c[13]};
                b = {b[6:0], c[12]};
            end
        end
        r = r << (8 - bits / 3);
        g = g << (8 - bits / 3);
        b = b << (8 - bits / 3);
        return {r, g, b};
    endfunction

    // Zero the border slots at the write pointer
    function automatic void zero_borders(input mode_info_t mi);
        int unsigned x;
        while (mi.border != 0 && wr_ptr < (mi.ncolors - mi.nfixed) * mi.height) begin
            x = wr_ptr % mi.ncolors;
            if (x != 0 && x != ((mi.ncolors - 1) & ~32'd15))
                break;
            store_wr(wr_ptr, 24'd0);
            wr_ptr = wr_ptr + 1'b1;
        end
    endfunction

    // Drain whole colors from the bit buffer into the store
    function automatic void drain_colors(input mode_info_t mi);
        int unsigned bits;
        logic [23:0] raw;
        bits = color_width(cur_ste, cur_extra);
        zero_borders(mi);
        while (bit_cnt >= bits && wr_ptr < (mi.ncolors - mi.nfixed) * mi.height) begin
            bit_cnt = bit_cnt - bits;
            raw = (bit_buf >> bit_cnt) & ((24'd1 << bits) - 1);
            store_wr(wr_ptr, expand_color(raw[14:0], bits));
            wr_ptr = wr_ptr + 1'b1;
            zero_borders(mi);
        end
    endfunction

    function automatic void clear_frame(input mode_info_t mi);
        bit_buf = '0; bit_cnt = '0; byte_cnt = '0; wr_ptr = '0; rd_ptr = '0;
        planes = '0; line_no = '0; col_no = '0; next_chg = mi.x0[8:0];
        chg_cnt = '0; image_phase = 1'b0;
        for (int i = 0; i < 16; i++)
            act_pal[i] = '0;
    endfunction

    // Work out the pixels that one accepted body byte causes
    function automatic void predict_pixels(input logic [7:0] data, input logic first);
        mode_info_t mi;
        pixel_t px;
        logic [3:0] pi;
        logic [23:0] rgb;
        mi = mode_info(cur_mode);
        if (first)
            clear_frame(mi);
        if (!image_phase) begin
            drain_colors(mi);
            if (wr_ptr < (mi.ncolors - mi.nfixed) * mi.height && bit_cnt <= 16) begin
                bit_buf = {bit_buf[15:0], data};
                bit_cnt = bit_cnt + 5'd8;
                drain_colors(mi);
            end
            byte_cnt = byte_cnt + 1'b1;
            if (byte_cnt >= packed_len(cur_mode, cur_ste, cur_extra)) begin
                image_phase = 1'b1;
                byte_cnt = '0;
            end
            return;
        end
        if (line_no >= mi.height)
            return;
        planes = {planes[55:0], data};
        byte_cnt = byte_cnt + 1'b1;
        if (byte_cnt[2:0] != 3'd0)
            return;
        for (int p = 0; p < 16 && line_no < mi.height; p++) begin
            // Load the line palette on the first column
            if (col_no == 0) begin
                rd_ptr = line_no * (mi.ncolors - mi.nfixed);
                for (int i = mi.nfixed; i < 16; i++) begin
                    act_pal[i] = store_rd(rd_ptr);
                    rd_ptr = rd_ptr + 1'b1;
                end
                next_chg = mi.x0[8:0];
                chg_cnt = '0;
            end
            // Apply the scheduled single-entry change
            if (col_no == next_chg) begin
                act_pal[chg_cnt[3:0]] = store_rd(rd_ptr);
                rd_ptr = rd_ptr + 1'b1;
                next_chg = next_chg + change_step(cur_mode, chg_cnt);
                chg_cnt = chg_cnt + 1'b1;
            end
            pi = {planes[15 - p], planes[31 - p], planes[47 - p], planes[63 - p]};
            rgb = act_pal[pi];
            px.red = rgb[23:16];
            px.green = rgb[15:8];
            px.blue = rgb[7:0];
            px.last_of_group = (p == 15);
            px.end_of_image = (line_no == mi.height - 1 && col_no == mi.width - 1);
            pixel_q.push_back(px);
            col_no = col_no + 1'b1;
            if (col_no >= mi.width) begin
                col_no = '0;
                line_no = line_no + 1'b1;
            end
        end
    endfunction

    // Clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Input driver: hold the byte until its transfer, then fetch the next one
    always @(negedge i_clk) begin
        if (i_rst_n && !holding) begin
            if (body_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                body_byte_t nb;
                nb = body_q.pop_front();
                i_data_byte   <= nb.data;
                i_frame_start <= nb.first;
                i_in_valid    <= 1'b1;
                holding = 1'b1;
            end else begin
                i_in_valid    <= 1'b0;
                i_data_byte   <= 8'($urandom);
                i_frame_start <= 1'($urandom);
            end
        end
    end

    // Output stall generator
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Monitor: predict on input transfers, check output transfers, track config writes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODE:  cur_mode  = i_cfg_data;
                    CFG_STE:   cur_ste   = i_cfg_data[0];
                    CFG_EXTRA: cur_extra = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                predict_pixels(i_data_byte, i_frame_start);
                holding = 1'b0;
            end
            if (o_out_valid && !i_out_stall) begin
                if (pixel_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel: r=%0d g=%0d b=%0d last=%0d eoi=%0d",
                                 o_red, o_green, o_blue, o_last_of_group, o_end_of_image);
                end else begin
                    pixel_t ex;
                    ex = pixel_q.pop_front();
                    if (ex.red !== o_red || ex.green !== o_green || ex.blue !== o_blue
                            || ex.last_of_group !== o_last_of_group
                            || ex.end_of_image !== o_end_of_image) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pixel mismatch: exp r=%0d g=%0d b=%0d last=%0d eoi=%0d,",
                                     ex.red, ex.green, ex.blue, ex.last_of_group,
                                     ex.end_of_image,
                                     " got r=%0d g=%0d b=%0d last=%0d eoi=%0d",
                                     o_red, o_green, o_blue, o_last_of_group,
                                     o_end_of_image);
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every byte is taken and every pixel has arrived, then let the block settle
    task automatic drain_all();
        wait (body_q.size() == 0 && !holding && pixel_q.size() == 0);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] m, input logic ste, input logic extra);
        write_reg(CFG_MODE, m);
        write_reg(CFG_STE, {1'b0, ste});
        write_reg(CFG_EXTRA, {1'b0, extra});
    endtask

    // Queue one picture: packed palette, image bytes and trailing bytes
    task automatic queue_picture(input logic [1:0] m, input logic ste, input logic extra,
                                 input int unsigned img_bytes, input int unsigned tail);
        int unsigned plen;
        plen = packed_len(m, ste, extra);
        for (int i = 0; i < plen; i++)
            body_q.push_back('{8'($urandom), i == 0});
        for (int i = 0; i < img_bytes; i++) begin
            logic [7:0] d;
            // first two groups all clear and all set planes
            d = i < 8 ? 8'h00 : i < 16 ? 8'hff : 8'($urandom);
            body_q.push_back('{d, 1'b0});
        end
        for (int i = 0; i < tail; i++)
            body_q.push_back('{8'($urandom), 1'b0});
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_data_byte   = '0;
        i_frame_start = 1'b0;
        i_out_stall   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        holding       = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        mismatches    = 0;
        cur_mode      = '0;
        cur_ste       = 1'b0;
        cur_extra     = 1'b0;
        clear_frame(mode_info(2'd0));
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Full picture with no idling: aborted start, whole image, ignored bytes after it
        set_mode(2'd1, 1'b0, 1'b0);
        body_q.push_back('{8'h00, 1'b1});
        body_q.push_back('{8'hff, 1'b0});
        body_q.push_back('{8'haa, 1'b0});
        body_q.push_back('{8'h55, 1'b0});
        for (int i = 0; i < 12; i++)
            body_q.push_back('{8'($urandom), 1'b0});
        queue_picture(2'd1, 1'b0, 1'b0, 199 * 320 / 2, 12);
        drain_all();

        // 12-bit colors, sender idling
        set_mode(2'd0, 1'b1, 1'b0);
        idle_pct = 81;
        queue_picture(2'd0, 1'b1, 1'b0, 400, 0);
        drain_all();

        // 12-bit colors by the extra bit, receiver stalling
        set_mode(2'd2, 1'b0, 1'b1);
        idle_pct  = 0;
        stall_pct = 81;
        queue_picture(2'd2, 1'b0, 1'b1, 400, 0);
        drain_all();

        // 15-bit colors, fixed entries, both sides idling, restart mid-image
        set_mode(2'd3, 1'b1, 1'b1);
        idle_pct  = 37;
        stall_pct = 37;
        queue_picture(2'd3, 1'b1, 1'b1, 400, 0);
        for (int i = 0; i < 20; i++)
            body_q.push_back('{8'($urandom), i == 0});
        drain_all();

        // Back to reset values, no idling
        set_mode(2'd0, 1'b0, 1'b0);
        idle_pct  = 0;
        stall_pct = 0;
        queue_picture(2'd0, 1'b0, 1'b0, 160, 0);
        drain_all();

        if (mismatches == 0 && pixel_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Timeout
    initial begin
        #400_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
